@@ hw/rtl/http_request_header_tokenizer_top_assert.svh @@
// Assertion macros for the HTTP request header tokenizer checker.
// Needs nothing else; included by the checker file.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_TOP_ASSERT_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_TOP_ASSERT_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define HTOK_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define HTOK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

@@ hw/rtl/htok_pkg.sv @@
// Shared types, codes and tag functions for the HTTP header tokenizer.
// No dependencies.
`default_nettype none
package htok_pkg;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Parse phases
    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_PATH    = 3'd1;
    localparam logic [2:0] PH_VERSION = 3'd2;
    localparam logic [2:0] PH_NAME    = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;
    localparam logic [2:0] PH_DISCARD = 3'd7;

    // Token classes
    localparam logic [2:0] TC_METHOD  = 3'd0;
    localparam logic [2:0] TC_PATH    = 3'd1;
    localparam logic [2:0] TC_VERSION = 3'd2;
    localparam logic [2:0] TC_NAME    = 3'd3;
    localparam logic [2:0] TC_VALUE   = 3'd4;
    localparam logic [2:0] TC_DELIM   = 3'd5;
    localparam logic [2:0] TC_BODY    = 3'd6;
    localparam logic [2:0] TC_DISCARD = 3'd7;

    typedef struct packed {
        logic [2:0] phase;
        logic       cr_pending;
        logic       line_at_start;
        logic       name_nonempty;
        logic       value_nonempty;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase: PH_METHOD, cr_pending: 1'b0, line_at_start: 1'b1,
        name_nonempty: 1'b0, value_nonempty: 1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] token_class;
        logic       header_line_end;
        logic       header_kept;
        logic       headers_done;
        logic       malformed;
        logic       last_of_run;
    } res_t;

    typedef struct packed {
        state_t     st;
        logic [2:0] cls;
    } take_t;

    // Build a result word with the run flag clear.
    function automatic res_t make_res(logic [7:0] b, logic [2:0] cls, logic hle,
                                      logic kept, logic done, logic mal);
        res_t r;
        r.out_byte        = b;
        r.token_class     = cls;
        r.header_line_end = hle;
        r.header_kept     = kept;
        r.headers_done    = done;
        r.malformed       = mal;
        r.last_of_run     = 1'b0;
        return r;
    endfunction

    // Tag one content byte in the current phase and advance the phase.
    function automatic take_t take(state_t s, logic [7:0] b);
        take_t t;
        t.st  = s;
        t.cls = TC_DISCARD;
        case (s.phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    t.st.phase = PH_PATH;
                    t.cls      = TC_DELIM;
                end else begin
                    t.cls = TC_METHOD;
                end
            end
            PH_PATH: begin
                if (b == CH_SP) begin
                    t.st.phase = PH_VERSION;
                    t.cls      = TC_DELIM;
                end else begin
                    t.cls = TC_PATH;
                end
            end
            PH_VERSION: t.cls = TC_VERSION;
            PH_NAME: begin
                t.st.line_at_start = 1'b0;
                if (b == CH_COLON) begin
                    t.st.phase = PH_SKIP;
                    t.cls      = TC_DELIM;
                end else begin
                    t.st.name_nonempty = 1'b1;
                    t.cls              = TC_NAME;
                end
            end
            PH_SKIP: begin
                if (b == CH_SP) begin
                    t.cls = TC_DELIM;
                end else begin
                    t.st.phase          = PH_VALUE;
                    t.st.value_nonempty = 1'b1;
                    t.cls               = TC_VALUE;
                end
            end
            PH_VALUE: begin
                t.st.value_nonempty = 1'b1;
                t.cls               = TC_VALUE;
            end
            PH_BODY: t.cls = TC_BODY;
            default: t.cls = TC_DISCARD;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/htok_core.sv @@
// Parse state registers and the per-byte tagging logic (up to two words per byte).
// Depends on htok_pkg.
`default_nettype none
module htok_core
    import htok_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       consume,
    input  wire logic [7:0] data_byte,
    input  wire logic       start_of_request,
    output logic [1:0]      res_count,
    output res_t            res0,
    output res_t            res1
);

    state_t state_reg;
    state_t state_next;
    res_t   res [2];
    logic [1:0] n;
    take_t  t;
    state_t s;
    logic   hle, kept, done, mal;

    // Walk one byte: flush, CRLF handling, then the byte itself
    always_comb begin
        s      = state_reg;
        n      = 2'd0;
        res[0] = make_res(8'h00, TC_DISCARD, 1'b0, 1'b0, 1'b0, 1'b0);
        res[1] = res[0];
        t      = '0;
        hle    = 1'b0;
        kept   = 1'b0;
        done   = 1'b0;
        mal    = 1'b0;

        // Flush a held CR as content of the old request, then restart
        if (start_of_request) begin
            if (s.cr_pending) begin
                t      = take(s, CH_CR);
                res[0] = make_res(CH_CR, t.cls, 1'b0, 1'b0, 1'b0, 1'b0);
                n      = 2'd1;
            end
            s = STATE_RESET;
        end

        if (s.cr_pending && data_byte == CH_LF) begin
            // CR LF closes the current line
            s.cr_pending = 1'b0;
            if (s.phase inside {[PH_METHOD:PH_VERSION]}) begin
                s.phase         = PH_NAME;
                s.line_at_start = 1'b1;
            end else if (s.phase == PH_NAME) begin
                if (s.line_at_start) begin
                    done    = 1'b1;
                    s.phase = PH_BODY;
                end else begin
                    hle     = 1'b1;
                    mal     = 1'b1;
                    s.phase = PH_DISCARD;
                end
            end else begin
                hle             = 1'b1;
                kept            = s.name_nonempty & s.value_nonempty;
                s.phase         = PH_NAME;
                s.line_at_start = 1'b1;
            end
            s.name_nonempty  = 1'b0;
            s.value_nonempty = 1'b0;
            res[0] = make_res(CH_CR, TC_DELIM, 1'b0, 1'b0, 1'b0, 1'b0);
            res[1] = make_res(CH_LF, TC_DELIM, hle, kept, done, mal);
            n      = 2'd2;
        end else begin
            // Lone CR becomes content
            if (s.cr_pending) begin
                s.cr_pending = 1'b0;
                t            = take(s, CH_CR);
                s            = t.st;
                res[n[0]]    = make_res(CH_CR, t.cls, 1'b0, 1'b0, 1'b0, 1'b0);
                n            = n + 2'd1;
            end
            // Hold a CR in line phases, otherwise tag the byte
            if (s.phase inside {[PH_METHOD:PH_VALUE]} && data_byte == CH_CR) begin
                s.cr_pending = 1'b1;
            end else begin
                t         = take(s, data_byte);
                s         = t.st;
                res[n[0]] = make_res(data_byte, t.cls, 1'b0, 1'b0, 1'b0, 1'b0);
                n         = n + 2'd1;
            end
        end

        // Mark the final word of this byte
        if (n == 2'd1) begin
            res[0].last_of_run = 1'b1;
        end else if (n == 2'd2) begin
            res[1].last_of_run = 1'b1;
        end
        state_next = s;
    end

    // Advance the parse state on each consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (consume) begin
            state_reg <= state_next;
        end
    end

    assign res_count = n;
    assign res0      = res[0];
    assign res1      = res[1];

endmodule
`default_nettype wire

@@ hw/rtl/htok_out_queue.sv @@
// Two-slot result register that drives the output channel.
// Depends on htok_pkg.
`default_nettype none
module htok_out_queue
    import htok_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire logic [1:0] push_count,
    input  wire res_t       push_res0,
    input  wire res_t       push_res1,
    output logic            room,
    output logic            out_valid,
    input  wire logic       out_ready,
    output res_t            out_res
);

    res_t       slot0_reg;
    res_t       slot1_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // Accept a new group only when the queue is empty or its last word leaves this cycle
    assign room      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign out_res   = slot0_reg;

    // Track the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (push) begin
            cnt_reg <= push_count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Load a group or shift the second word forward
    always_ff @(posedge aclk) begin
        if (push) begin
            slot0_reg <= push_res0;
            slot1_reg <= push_res1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/http_request_header_tokenizer_top.sv @@
// HTTP request header tokenizer: one byte per cycle. Each byte enters an input
// register and is tagged in the following cycle into zero, one or two result
// words (a held CR gives none; a CR LF pair gives two, as does any other byte
// that follows a held CR unless it is held itself). Throughput is one byte per
// cycle while each byte yields at most one word and m_ready stays high; a byte
// that yields two words fills the two-slot output register and stalls input.
// Depends on htok_pkg, htok_core and htok_out_queue.
`default_nettype none
module http_request_header_tokenizer_top
    import htok_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_start_of_request,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [2:0]      m_token_class,
    output logic            m_header_line_end,
    output logic            m_header_kept,
    output logic            m_headers_done,
    output logic            m_malformed,
    output logic            m_last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_sor_reg;
    logic       room;
    logic       consume;
    logic       push;
    logic [1:0] res_count;
    res_t       res0;
    res_t       res1;
    res_t       out_res;

    assign consume = in_valid_reg && room;
    assign push    = consume && (res_count != 2'd0);
    assign s_ready = !in_valid_reg || consume;

    // Hold the incoming word until the tagger consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_sor_reg  <= s_start_of_request;
        end
    end

    htok_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .consume          (consume),
        .data_byte        (in_byte_reg),
        .start_of_request (in_sor_reg),
        .res_count        (res_count),
        .res0             (res0),
        .res1             (res1)
    );

    htok_out_queue u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_count (res_count),
        .push_res0  (res0),
        .push_res1  (res1),
        .room       (room),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_res    (out_res)
    );

    assign m_out_byte        = out_res.out_byte;
    assign m_token_class     = out_res.token_class;
    assign m_header_line_end = out_res.header_line_end;
    assign m_header_kept     = out_res.header_kept;
    assign m_headers_done    = out_res.headers_done;
    assign m_malformed       = out_res.malformed;
    assign m_last_of_run     = out_res.last_of_run;

endmodule
`default_nettype wire

@@ hw/rtl/htok_checker.sv @@
// Port-level checks for the HTTP header tokenizer, bound to the top level.
// Depends on htok_pkg and http_request_header_tokenizer_top_assert.svh.
`default_nettype none
`include "http_request_header_tokenizer_top_assert.svh"
module htok_checker
    import htok_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic [2:0] m_token_class,
    input wire logic       m_header_line_end,
    input wire logic       m_header_kept,
    input wire logic       m_headers_done,
    input wire logic       m_malformed,
    input wire logic       m_last_of_run
);

    logic        out_stall;
    logic [10:0] out_tag;
    logic        end_flag;
    logic        lf_last;
    logic        flag_set;
    logic        flag_ok;

    assign out_stall = m_valid && !m_ready;
    assign out_tag   = {m_out_byte, m_token_class};
    assign end_flag  = m_valid && (m_header_line_end || m_headers_done);
    assign lf_last   = (m_out_byte == CH_LF) && (m_token_class == TC_DELIM) && m_last_of_run;
    assign flag_set  = m_valid && (m_header_kept || m_malformed);
    assign flag_ok   = m_header_line_end && !(m_header_kept && m_malformed);

    // A stalled word holds
    `HTOK_ASSERT_NEXT(a_stall_hold, aclk, aresetn, out_stall, m_valid && $stable(out_tag))

    // Line-end flags ride only on a delimiter LF that closes its byte's run
    `HTOK_ASSERT_SAME(a_line_end_lf, aclk, aresetn, end_flag, lf_last)

    // Kept and malformed only accompany a header line end, never both
    `HTOK_ASSERT_SAME(a_flag_scope, aclk, aresetn, flag_set, flag_ok)

    // Blank line is not a header line end
    `HTOK_ASSERT_SAME(a_done_excl, aclk, aresetn, m_valid && m_headers_done, !m_header_line_end)

endmodule

bind http_request_header_tokenizer_top htok_checker u_htok_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_out_byte        (m_out_byte),
    .m_token_class     (m_token_class),
    .m_header_line_end (m_header_line_end),
    .m_header_kept     (m_header_kept),
    .m_headers_done    (m_headers_done),
    .m_malformed       (m_malformed),
    .m_last_of_run     (m_last_of_run)
);
`default_nettype wire

@@ sim/http_request_header_tokenizer_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the HTTP request header tokenizer: watches both channels, predicts
// the tagged words of every accepted byte and compares them in order of arrival.
// Depends on htok_pkg for the byte, phase and token class codes.
module http_request_header_tokenizer_checker
    import htok_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_start_of_request,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_out_byte,
    input  wire logic [2:0] m_token_class,
    input  wire logic       m_header_line_end,
    input  wire logic       m_header_kept,
    input  wire logic       m_headers_done,
    input  wire logic       m_malformed,
    input  wire logic       m_last_of_run,
    output int              mismatch_count,
    output int              words_outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] cls;
        logic       line_end;
        logic       kept;
        logic       done;
        logic       bad_line;
        logic       last;
    } tag_word_t;

    // Shadow parser state
    logic [2:0] phase;
    logic       cr_held;
    logic       line_fresh;
    logic       name_seen;
    logic       value_seen;

    tag_word_t  tag_q[$];
    int         fail_tally = 0;
    int         word_index = 0;

    function automatic tag_word_t tag_word(input logic [7:0] data, input logic [2:0] cls,
                                           input logic line_end, input logic kept,
                                           input logic done, input logic bad_line);
        tag_word_t w;
        w.data     = data;
        w.cls      = cls;
        w.line_end = line_end;
        w.kept     = kept;
        w.done     = done;
        w.bad_line = bad_line;
        w.last     = 1'b0;
        return w;
    endfunction

    task automatic restart_parse();
        phase      = PH_METHOD;
        cr_held    = 1'b0;
        line_fresh = 1'b1;
        name_seen  = 1'b0;
        value_seen = 1'b0;
    endtask

    // Classify one content byte in the current phase and advance the phase.
    function automatic logic [2:0] tag_content(input logic [7:0] b);
        logic [2:0] cls;
        cls = TC_DISCARD;
        case (phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    phase = PH_PATH;
                    cls   = TC_DELIM;
                end else begin
                    cls = TC_METHOD;
                end
            end
            PH_PATH: begin
                if (b == CH_SP) begin
                    phase = PH_VERSION;
                    cls   = TC_DELIM;
                end else begin
                    cls = TC_PATH;
                end
            end
            PH_VERSION: cls = TC_VERSION;
            PH_NAME: begin
                line_fresh = 1'b0;
                if (b == CH_COLON) begin
                    phase = PH_SKIP;
                    cls   = TC_DELIM;
                end else begin
                    name_seen = 1'b1;
                    cls       = TC_NAME;
                end
            end
            PH_SKIP: begin
                if (b == CH_SP) begin
                    cls = TC_DELIM;
                end else begin
                    phase      = PH_VALUE;
                    value_seen = 1'b1;
                    cls        = TC_VALUE;
                end
            end
            PH_VALUE: begin
                value_seen = 1'b1;
                cls        = TC_VALUE;
            end
            PH_BODY: cls = TC_BODY;
            default: cls = TC_DISCARD;
        endcase
        return cls;
    endfunction

    // Work out the words one accepted byte causes and queue them.
    task automatic predict_byte(input logic [7:0] b, input logic sor);
        tag_word_t run [2];
        int        n;
        logic      crlf;
        logic      line_end;
        logic      kept;
        logic      done;
        logic      bad_line;
        n        = 0;
        crlf     = 1'b0;
        line_end = 1'b0;
        kept     = 1'b0;
        done     = 1'b0;
        bad_line = 1'b0;

        // Flush a held CR into the old request, then start over
        if (sor) begin
            if (cr_held) begin
                cr_held = 1'b0;
                run[n]  = tag_word(CH_CR, tag_content(CH_CR), 1'b0, 1'b0, 1'b0, 1'b0);
                n++;
            end
            restart_parse();
        end

        if (cr_held) begin
            cr_held = 1'b0;
            if (b == CH_LF) begin
                crlf   = 1'b1;
                run[n] = tag_word(CH_CR, TC_DELIM, 1'b0, 1'b0, 1'b0, 1'b0);
                n++;
                if (phase <= PH_VERSION) begin
                    phase      = PH_NAME;
                    line_fresh = 1'b1;
                end else if (phase == PH_NAME) begin
                    if (line_fresh) begin
                        done  = 1'b1;
                        phase = PH_BODY;
                    end else begin
                        line_end = 1'b1;
                        bad_line = 1'b1;
                        phase    = PH_DISCARD;
                    end
                end else begin
                    line_end   = 1'b1;
                    kept       = name_seen && value_seen;
                    phase      = PH_NAME;
                    line_fresh = 1'b1;
                end
                name_seen  = 1'b0;
                value_seen = 1'b0;
                run[n]     = tag_word(CH_LF, TC_DELIM, line_end, kept, done, bad_line);
                n++;
            end else begin
                // Lone CR: plain content of the current phase
                run[n] = tag_word(CH_CR, tag_content(CH_CR), 1'b0, 1'b0, 1'b0, 1'b0);
                n++;
            end
        end

        if (!crlf) begin
            if (phase <= PH_VALUE && b == CH_CR) begin
                cr_held = 1'b1;
            end else begin
                run[n] = tag_word(b, tag_content(b), 1'b0, 1'b0, 1'b0, 1'b0);
                n++;
            end
        end

        if (n > 0) run[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) tag_q.push_back(run[i]);
    endtask

    task automatic report_word(input tag_word_t want, input tag_word_t got);
        fail_tally++;
        if (fail_tally <= 10) begin
            $display("tokenizer word %0d: expected byte %02h cls %0d hle %0d kept %0d done %0d",
                     word_index, want.data, want.cls, want.line_end, want.kept, want.done);
            $display("    mal %0d last %0d; got byte %02h cls %0d hle %0d kept %0d done %0d",
                     want.bad_line, want.last, got.data, got.cls, got.line_end, got.kept,
                     got.done);
            $display("    mal %0d last %0d", got.bad_line, got.last);
        end
    endtask

    // Predict on input accepts, compare on output accepts
    always @(posedge aclk) begin : monitor
        tag_word_t got;
        tag_word_t want;
        if (!aresetn) begin
            restart_parse();
            tag_q.delete();
        end else begin
            if (s_valid && s_ready) predict_byte(s_data_byte, s_start_of_request);
            if (m_valid && m_ready) begin
                got.data     = m_out_byte;
                got.cls      = m_token_class;
                got.line_end = m_header_line_end;
                got.kept     = m_header_kept;
                got.done     = m_headers_done;
                got.bad_line = m_malformed;
                got.last     = m_last_of_run;
                if (tag_q.size() == 0) begin
                    fail_tally++;
                    if (fail_tally <= 10)
                        $display("tokenizer word %0d: nothing expected, got byte %02h cls %0d",
                                 word_index, got.data, got.cls);
                end else begin
                    want = tag_q.pop_front();
                    if (want !== got) report_word(want, got);
                end
                word_index++;
            end
        end
        mismatch_count    <= fail_tally;
        words_outstanding <= tag_q.size();
    end

endmodule

@@ sim/http_request_header_tokenizer_top_test.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the HTTP request header tokenizer: directed requests, then
// random well-formed, damaged and noise requests with random idling on both channels.
// Depends on htok_pkg, the tokenizer RTL and http_request_header_tokenizer_checker.
module http_request_header_tokenizer_top_test;
    import htok_pkg::*;

    localparam int ITEM_TARGET   = 2000;
    localparam int IDLE_PCT      = 29;
    localparam int SETTLE_CYCLES = 20;
    localparam int CALM_FROM     = 40;
    localparam int CALM_SPAN     = 15;
    localparam int OPENING_LEN   = 29;

    // Directed bytes, bit 8 marks the start of a request
    localparam logic [8:0] OPENING [OPENING_LEN] = '{
        // method cut short by CR LF, empty name, blank line, body
        {1'b1, 8'h47}, {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, CH_COLON},
        {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, 8'hFF},
        // lone CR and lone LF in the path, CR held into the next request
        {1'b1, 8'h41}, {1'b0, CH_SP}, {1'b0, CH_CR}, {1'b0, 8'h78}, {1'b0, CH_LF},
        {1'b0, CH_SP}, {1'b0, CH_CR},
        // kept header with skipped space, line without colon, discard
        {1'b1, 8'h6B}, {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, 8'h68}, {1'b0, CH_COLON},
        {1'b0, CH_SP}, {1'b0, 8'h76}, {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, 8'h6E},
        {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, 8'h00}
    };

    logic       aclk               = 1'b0;
    logic       aresetn            = 1'b0;
    logic       s_valid            = 1'b0;
    logic [7:0] s_data_byte        = 8'h00;
    logic       s_start_of_request = 1'b0;
    logic       m_ready            = 1'b0;
    logic       calm               = 1'b0;

    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic [2:0] m_token_class;
    logic       m_header_line_end;
    logic       m_header_kept;
    logic       m_headers_done;
    logic       m_malformed;
    logic       m_last_of_run;

    int         mismatch_count;
    int         words_outstanding;
    int         bytes_sent    = 0;
    int         requests_sent = 0;
    logic [7:0] frame_q[$];

    http_request_header_tokenizer_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_start_of_request (s_start_of_request),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_token_class      (m_token_class),
        .m_header_line_end  (m_header_line_end),
        .m_header_kept      (m_header_kept),
        .m_headers_done     (m_headers_done),
        .m_malformed        (m_malformed),
        .m_last_of_run      (m_last_of_run)
    );

    http_request_header_tokenizer_checker tag_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_start_of_request (s_start_of_request),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_token_class      (m_token_class),
        .m_header_line_end  (m_header_line_end),
        .m_header_kept      (m_header_kept),
        .m_headers_done     (m_headers_done),
        .m_malformed        (m_malformed),
        .m_last_of_run      (m_last_of_run),
        .mismatch_count     (mismatch_count),
        .words_outstanding  (words_outstanding)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Hard stop for a hung run
    initial begin
        #2_000_000;
        $display("http_request_header_tokenizer_top: mismatch");
        $finish;
    end

    // Stall the result side at random outside the calm stretch
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Offer one word after a random gap and hold it until accepted.
    task automatic send_word(input logic [7:0] b, input logic sor);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_data_byte        <= b;
        s_start_of_request <= sor;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Append token text: mostly printable, never SP or CR, colon only if allowed.
    task automatic append_text(input int len, input logic colon_ok);
        logic [7:0] c;
        repeat (len) begin
            if ($urandom_range(15) == 0) c = 8'($urandom_range(255));
            else c = 8'($urandom_range(8'h21, 8'h7E));
            if (c == CH_SP || c == CH_CR || (c == CH_COLON && !colon_ok)) c = 8'h2D;
            frame_q.push_back(c);
        end
    endtask

    initial begin : stimulus
        int kind;
        int cut;

        // Hold reset
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < OPENING_LEN; i++) send_word(OPENING[i][7:0], OPENING[i][8]);

        while (bytes_sent < ITEM_TARGET) begin
            if (requests_sent == CALM_FROM) calm <= 1'b1;
            if (requests_sent == CALM_FROM + CALM_SPAN) calm <= 1'b0;

            // Pause the sender until the block has drained
            if (requests_sent % 60 == 25) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (words_outstanding != 0) @(posedge aclk);
            end

            kind = $urandom_range(9);
            if (kind < 8) begin
                // Build a request: line, headers, blank line, body
                frame_q.delete();
                append_text($urandom_range(1, 4), 1'b1);
                frame_q.push_back(CH_SP);
                append_text($urandom_range(1, 6), 1'b1);
                frame_q.push_back(CH_SP);
                append_text($urandom_range(1, 4), 1'b1);
                frame_q.push_back(CH_CR);
                frame_q.push_back(CH_LF);
                repeat ($urandom_range(0, 4)) begin
                    append_text($urandom_range(0, 4), 1'b0);
                    if ($urandom_range(7) != 0) begin
                        frame_q.push_back(CH_COLON);
                        repeat ($urandom_range(0, 2)) frame_q.push_back(CH_SP);
                        append_text($urandom_range(0, 5), 1'b1);
                    end
                    frame_q.push_back(CH_CR);
                    frame_q.push_back(CH_LF);
                end
                frame_q.push_back(CH_CR);
                frame_q.push_back(CH_LF);
                repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(255)));

                // Damage some requests: stray bytes and an early cut
                if (kind == 7) begin
                    foreach (frame_q[i])
                        if ($urandom_range(9) == 0) frame_q[i] = 8'($urandom_range(255));
                    cut = $urandom_range(1, frame_q.size());
                    while (frame_q.size() > cut) void'(frame_q.pop_back());
                end

                foreach (frame_q[i]) send_word(frame_q[i], i == 0);
            end else begin
                // Raw noise with a rare start flag
                repeat ($urandom_range(4, 20))
                    send_word(8'($urandom_range(255)), $urandom_range(15) == 0);
            end
            requests_sent++;
        end

        // Drain and settle
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && words_outstanding == 0) begin
            $display("http_request_header_tokenizer_top: match");
        end else begin
            $display("http_request_header_tokenizer_top: mismatch");
        end
        $finish;
    end

endmodule
